### rtl/rde_pkg.sv
// Package: shared constants, types and state encoding for the radix digit encoder.
package rde_pkg;

    localparam int VAL_W       = 32;
    localparam int RADIX_W     = 6;
    localparam int SYM_W       = 6;
    localparam int SLOT_W      = 6;
    localparam int END_W       = 7;
    localparam int REM_W       = 5;
    localparam int CNT_W       = $clog2(VAL_W);
    localparam int MAX_SLOTS   = 64;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 16;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd32;
    localparam logic [SYM_W-1:0]   DIGIT_BIAS  = 6'd32;
    localparam logic [SYM_W-1:0]   PAD_SYMBOL  = 6'd31;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    typedef struct packed {
        logic [SYM_W-1:0]  sym;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_out_item;

endpackage

### rtl/rde_div_unit.sv
// Bit-serial restoring divider: unsigned magnitude by radix, one quotient bit per cycle.
module rde_div_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rde_pkg::VAL_W-1:0]     i_dividend,
    input  logic [rde_pkg::RADIX_W-1:0]   i_radix,
    output rde_pkg::t_div_status          o_status,
    output logic [rde_pkg::VAL_W-1:0]     o_quotient,
    output logic [rde_pkg::REM_W-1:0]     o_remainder
);
    import rde_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VAL_W - 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [VAL_W-1:0] r_quo, n_quo;
    logic [REM_W-1:0] r_rem, n_rem;

    logic [RADIX_W-1:0] rem_sh;
    logic [RADIX_W-1:0] rem_sub;
    logic               ge;

    assign rem_sh  = {r_rem, r_quo[VAL_W-1]};
    assign ge      = (rem_sh >= i_radix);
    assign rem_sub = rem_sh - i_radix;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            n_quo = {r_quo[VAL_W-2:0], ge};
            n_rem = ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_quo;
    assign o_remainder   = r_rem;

endmodule

### rtl/rde_out_reg.sv
// Output register: holds one symbol request until the downstream side takes it.
module rde_out_reg (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  rde_pkg::t_out_item       i_item,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [rde_pkg::OUT_TDATA_W-1:0] o_m_tdata,  // symbol[5:0], slot[11:6], zero pad
    output logic                     o_m_tlast
);
    import rde_pkg::*;

    logic      r_valid, n_valid;
    t_out_item r_item, n_item;

    assign o_ready = !r_valid || i_m_tready;

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (o_ready) begin
            n_valid = i_valid;
            if (i_valid) begin
                n_item = i_item;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W - SYM_W - SLOT_W){1'b0}}, r_item.slot, r_item.sym};
    assign o_m_tlast  = r_item.last;

endmodule

### rtl/radix_digit_encoder_top.sv
// Top level: slot sequencer, radix register, divider and output register.
// Each digit slot runs the 32-step bit-serial divider, with a load and a capture around it;
// a pad slot needs no division. Requests are taken one at a time, each covering up to
// 64 slots; a new request is accepted only once the sequencer is back in idle.
// Reset (synchronous, active low) clears control state and sets radix to 10.
module radix_digit_encoder_top #(
    parameter int MAX_SLOTS = rde_pkg::MAX_SLOTS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rde_pkg::RADIX_W-1:0]       i_cfg_data,   // radix
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [rde_pkg::IN_TDATA_W-1:0]    i_s_tdata,    // value[31:0], start[37:32],
                                                            // end[44:38], zero pad
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [rde_pkg::OUT_TDATA_W-1:0]   o_m_tdata,    // symbol[5:0], slot[11:6], zero pad
    output logic                              o_m_tlast
);
    import rde_pkg::*;

    localparam logic [END_W-1:0] END_LIMIT = END_W'(MAX_SLOTS);

    t_state            r_state, n_state;
    logic [RADIX_W-1:0] r_radix;
    logic [VAL_W-1:0]  r_mag, n_mag;
    logic              r_neg, n_neg;
    logic [SLOT_W-1:0] r_pos, n_pos;
    logic [END_W-1:0]  r_end, n_end;
    logic [SYM_W-1:0]  r_sym, n_sym;

    logic [VAL_W-1:0]   in_val;
    logic [SLOT_W-1:0]  in_start;
    logic [END_W-1:0]   in_end;
    logic [END_W-1:0]   end_clamp;
    logic [VAL_W-1:0]   in_abs;
    logic [RADIX_W-1:0] radix_eff;
    logic               accept;
    logic               is_last;

    logic               div_start;
    logic [VAL_W-1:0]   div_dividend;
    t_div_status        div_status;
    logic [VAL_W-1:0]   div_quo;
    logic [REM_W-1:0]   div_rem;

    logic               emit_ready;
    t_out_item          emit_item;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign accept      = i_s_tvalid && o_s_tready;

    assign in_val    = i_s_tdata[VAL_W-1:0];
    assign in_start  = i_s_tdata[VAL_W+SLOT_W-1:VAL_W];
    assign in_end    = i_s_tdata[VAL_W+SLOT_W+END_W-1:VAL_W+SLOT_W];
    assign end_clamp = (in_end > END_LIMIT) ? END_LIMIT : in_end;
    assign in_abs    = in_val[VAL_W-1] ? (~in_val + 1'b1) : in_val;

    always_comb begin
        priority if (r_radix < RADIX_MIN) begin
            radix_eff = RADIX_MIN;
        end else if (r_radix > RADIX_MAX) begin
            radix_eff = RADIX_MAX;
        end else begin
            radix_eff = r_radix;
        end
    end

    assign is_last        = (({1'b0, r_pos} + 1'b1) == r_end);
    assign emit_item.sym  = r_sym;
    assign emit_item.slot = r_pos;
    assign emit_item.last = is_last;

    always_comb begin
        n_state      = r_state;
        n_mag        = r_mag;
        n_neg        = r_neg;
        n_pos        = r_pos;
        n_end        = r_end;
        n_sym        = r_sym;
        div_start    = 1'b0;
        div_dividend = r_mag;
        unique case (r_state)
            ST_IDLE: begin
                div_dividend = in_abs;
                if (accept) begin
                    n_neg = in_val[VAL_W-1];
                    n_mag = in_abs;
                    n_pos = in_start;
                    n_end = end_clamp;
                    if (end_clamp > {1'b0, in_start}) begin
                        if (in_abs != '0) begin
                            div_start = 1'b1;
                            n_state   = ST_DIV;
                        end else begin
                            n_sym   = PAD_SYMBOL;
                            n_state = ST_EMIT;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_status.done) begin
                    n_mag   = div_quo;
                    n_sym   = r_neg ? (DIGIT_BIAS - {1'b0, div_rem})
                                    : (DIGIT_BIAS + {1'b0, div_rem});
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_ready) begin
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_pos = r_pos + 1'b1;
                        if (r_mag != '0) begin
                            div_start = 1'b1;
                            n_state   = ST_DIV;
                        end else begin
                            n_sym = PAD_SYMBOL;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_radix <= RADIX_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_radix <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        r_neg <= n_neg;
        r_pos <= n_pos;
        r_end <= n_end;
        r_sym <= n_sym;
    end

    rde_div_unit u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_radix     (radix_eff),
        .o_status    (div_status),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    rde_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_state == ST_EMIT),
        .o_ready    (emit_ready),
        .i_item     (emit_item),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

### rtl/rde_checker.sv
// Port-level checker for the radix digit encoder, bound to the top level.
module rde_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_cfg_valid,
    input logic                              o_cfg_ready,
    input logic [rde_pkg::RADIX_W-1:0]       i_cfg_data,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic [rde_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [rde_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    input logic                              o_m_tlast
);
    import rde_pkg::*;

    // stalled output request holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("output request changed while stalled");

    // mid-window symbol means the sequencer still has slots to go
    a_busy_mid_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> !o_s_tready)
        else $error("input ready before window finished");

    // symbols never drop to zero
    a_sym_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[SYM_W-1:0] != '0))
        else $error("zero symbol emitted");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && o_s_tready))
        else $error("not idle after reset");

endmodule

bind radix_digit_encoder_top rde_checker u_rde_checker (.*);
